@@ hw/rtl/utu_pkg.sv @@
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8 transcoder.
package utu_pkg;

	localparam logic [15:0] MAX_UNITS_RESET = 16'd64;
	localparam int          QUEUE_DEPTH     = 2;

	localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
	localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
	localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
	localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE     = 21'h10000;
	localparam logic [20:0] ONE_BYTE_LIM  = 21'h80;
	localparam logic [20:0] TWO_BYTE_LIM  = 21'h800;
	localparam logic [20:0] THREE_BYTE_LIM = 21'h10000;

	// one code point in UTF-8, bytes[0] goes out first
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
	} enc_t;

	// work for the back end: the bytes one item causes
	typedef struct packed {
		logic [5:0][7:0] bytes;
		logic [2:0]      count;
		logic            marker;
		logic            str_end;
	} job_t;

	function automatic enc_t utf8_encode(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < ONE_BYTE_LIM) begin
			e.bytes[0] = cp[7:0];
			e.len      = 3'd1;
		end else if (cp < TWO_BYTE_LIM) begin
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
			e.len      = 3'd2;
		end else if (cp < THREE_BYTE_LIM) begin
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
			e.len      = 3'd3;
		end else begin
			e.bytes[0] = {5'b11110, cp[20:18]};
			e.bytes[1] = {2'b10, cp[17:12]};
			e.bytes[2] = {2'b10, cp[11:6]};
			e.bytes[3] = {2'b10, cp[5:0]};
			e.len      = 3'd4;
		end
		return e;
	endfunction

endpackage

@@ hw/rtl/utf16_to_utf8_transcoder_unit.sv @@
// Top level of the UTF-16 to UTF-8 transcoder.
//
//  channel  handshake                  payload
//  cfg      cfg_wr_en                  cfg_wr_data (max_units)
//  in       in_valid / in_ready        code_unit, last_unit
//  out      out_valid / out_ready      out_byte, byte_valid, run_last, string_end
//
// A code unit yields 0 to 6 bytes (1 to 3 for BMP characters, 4 for a pair,
// up to 6 for a flushed surrogate plus unit; a held high surrogate or a
// silent unit yields none). The output port sends one byte per cycle while
// out_ready is high.
// in_ready drops only when the job queue is full; the output register lets the
// next byte load in the cycle the current one is taken.
// arst_n clears all control state and sets max_units to 64; no clearing pass.
module utf16_to_utf8_transcoder_unit #(
	parameter int QUEUE_DEPTH = utu_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic        string_end
);
	import utu_pkg::*;

	logic push;
	job_t push_job;
	logic pop;
	job_t head_job;
	logic full;
	logic empty;

	utu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.code_unit   (code_unit),
		.last_unit   (last_unit),
		.queue_full  (full),
		.push        (push),
		.push_job    (push_job)
	);

	utu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (full),
		.empty    (empty)
	);

	utu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

@@ hw/rtl/utu_front.sv @@
// Front end: takes code units, tracks surrogate and string state, builds byte jobs.
module utu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [15:0]      cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [15:0]      code_unit,
	input  logic             last_unit,
	input  logic             queue_full,
	output logic             push,
	output utu_pkg::job_t    push_job
);
	import utu_pkg::*;

	logic [15:0] max_units_q;
	logic        held_valid_q;
	logic [9:0]  held_bits_q;
	logic        stopped_q;
	logic [15:0] unit_count_q;

	logic        nx_held_valid;
	logic [9:0]  nx_held_bits;
	logic        nx_stopped;
	logic [15:0] nx_count;
	logic        accept;
	logic        drop;
	logic        at_end;
	logic        is_high;
	logic        is_low;
	logic        a_en;
	logic        pair;
	logic        b_en;
	logic [15:0] cnt_inc;
	logic [20:0] pair_cp;
	enc_t        enc_a;
	enc_t        enc_b;
	logic [2:0]  len_a;
	logic [2:0]  len_b;
	job_t        job;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		drop    = stopped_q || (unit_count_q >= max_units_q);
		cnt_inc = unit_count_q + 16'd1;
		at_end  = last_unit || (cnt_inc == max_units_q);
		is_high = code_unit inside {[SURR_HI_FIRST:SURR_HI_LAST]};
		is_low  = code_unit inside {[SURR_LO_FIRST:SURR_LO_LAST]};
		pair_cp = SUPP_BASE + {1'b0, held_bits_q, code_unit[9:0]};

		a_en          = 1'b0;
		pair          = 1'b0;
		b_en          = 1'b0;
		nx_held_valid = held_valid_q;
		nx_held_bits  = held_bits_q;
		nx_stopped    = stopped_q;
		nx_count      = unit_count_q;

		if (drop) begin
			// a dropped unit still flushes a pending high surrogate
			a_en          = held_valid_q;
			nx_held_valid = 1'b0;
		end else begin
			nx_count = cnt_inc;
			if (held_valid_q) begin
				a_en          = 1'b1;
				pair          = is_low;
				nx_held_valid = 1'b0;
			end
			if (!(held_valid_q && is_low)) begin
				if (code_unit == 16'h0000) begin
					nx_stopped = 1'b1;
				end else if (is_high && !at_end) begin
					nx_held_valid = 1'b1;
					nx_held_bits  = code_unit[9:0];
				end else begin
					b_en = 1'b1;
				end
			end
		end

		enc_a = pair ? utf8_encode(pair_cp) : utf8_encode({5'b0, 6'b110110, held_bits_q});
		enc_b = utf8_encode({5'b0, code_unit});
		len_a = a_en ? enc_a.len : 3'd0;
		len_b = b_en ? enc_b.len : 3'd0;

		job = '0;
		case (len_a)
			3'd0: begin
				job.bytes[3:0] = enc_b.bytes;
			end
			3'd3: begin
				job.bytes[2:0] = enc_a.bytes[2:0];
				job.bytes[5:3] = enc_b.bytes[2:0];
			end
			default: begin
				// surrogate pair: nothing follows it
				job.bytes[3:0] = enc_a.bytes;
			end
		endcase
		job.count   = len_a + len_b;
		job.str_end = last_unit;
		if (last_unit && job.count == 3'd0) begin
			job.count  = 3'd1;
			job.marker = 1'b1;
		end
	end

	assign push     = accept && (job.count != 3'd0);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q  <= MAX_UNITS_RESET;
			held_valid_q <= 1'b0;
			held_bits_q  <= '0;
			stopped_q    <= 1'b0;
			unit_count_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				max_units_q <= cfg_wr_data;
			end
			if (accept) begin
				if (last_unit) begin
					held_valid_q <= 1'b0;
					held_bits_q  <= '0;
					stopped_q    <= 1'b0;
					unit_count_q <= '0;
				end else begin
					held_valid_q <= nx_held_valid;
					held_bits_q  <= nx_held_bits;
					stopped_q    <= nx_stopped;
					unit_count_q <= nx_count;
				end
			end
		end
	end

endmodule

@@ hw/rtl/utu_queue.sv @@
// Short job queue between front and back end.
module utu_queue #(
	parameter int DEPTH = utu_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  utu_pkg::job_t push_job,
	input  logic          pop,
	output utu_pkg::job_t head_job,
	output logic          full,
	output logic          empty
);
	import utu_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/utu_back.sv @@
// Back end: drains jobs one byte a cycle into the free output register.
module utu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  utu_pkg::job_t head_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          run_last,
	output logic          string_end
);
	import utu_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       run_last_q;
	logic       string_end_q;
	logic       load;
	logic       final_byte;

	assign load       = !empty && (!out_valid_q || out_ready);
	assign final_byte = (idx_q == (head_job.count - 3'd1));
	assign pop        = load && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= final_byte ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= head_job.marker ? 8'h00 : head_job.bytes[idx_q];
			byte_valid_q <= !head_job.marker;
			run_last_q   <= final_byte;
			string_end_q <= final_byte && head_job.str_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

endmodule

@@ bench/utf16_to_utf8_transcoder_unit_test.sv @@
// Self-checking testbench for the UTF-16 to UTF-8 transcoder unit.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_unit_test;
	import utu_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [15:0] code;
		logic        last;
	} unit_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       data_ok;
		logic       run_end;
		logic       str_end;
	} utf8_byte_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [15:0] code_unit   = '0;
	logic        last_unit   = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_last;
	logic        string_end;

	unit_item_t pending_units[$];
	utf8_byte_t due_bytes[$];
	utf8_byte_t step_bytes[$];
	unit_item_t next_unit;

	// shadow of the transcoder state
	logic [15:0] cap_units;
	logic        held_high;
	logic [9:0]  held_low_bits;
	logic        string_stopped;
	logic [15:0] units_seen;

	int  mismatches = 0;
	int  cycles     = 0;
	int  send_gap   = 0;
	int  recv_gap   = 0;
	int  recv_draw;
	bit  send_calm  = 1'b0;
	bit  recv_calm  = 1'b0;
	utf8_byte_t got_byte;
	utf8_byte_t want_byte;

	utf16_to_utf8_transcoder_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_unit  (code_unit),
		.last_unit  (last_unit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int draw_gap(input bit calm);
		if (calm || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	task automatic put_byte(input logic [7:0] b);
		utf8_byte_t rec;
		rec = '{data: b, data_ok: 1'b1, run_end: 1'b0, str_end: 1'b0};
		step_bytes.insert(step_bytes.size(), rec);
	endtask

	task automatic emit_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			put_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			put_byte({3'b110, cp[10:6]});
			put_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			put_byte({4'b1110, cp[15:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end else begin
			put_byte({5'b11110, cp[20:18]});
			put_byte({2'b10, cp[17:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end
	endtask

	// a high surrogate that found no partner goes out on its own
	task automatic flush_high();
		if (held_high) begin
			emit_code_point({5'd0, SURR_HI_FIRST[15:10], held_low_bits});
			held_high     = 1'b0;
			held_low_bits = '0;
		end
	endtask

	task automatic transcode_unit(input logic [15:0] u, input logic last);
		logic        at_end;
		logic        paired;
		logic [20:0] cp;
		utf8_byte_t  marker;
		step_bytes.delete();
		if (string_stopped || units_seen >= cap_units) begin
			flush_high();
		end else begin
			units_seen = units_seen + 16'd1;
			at_end     = last || units_seen == cap_units;
			paired     = 1'b0;
			if (held_high) begin
				if (u >= SURR_LO_FIRST && u <= SURR_LO_LAST) begin
					cp = SUPP_BASE + {1'b0, held_low_bits, 10'd0} + {5'd0, u - SURR_LO_FIRST};
					emit_code_point(cp);
					held_high     = 1'b0;
					held_low_bits = '0;
					paired        = 1'b1;
				end else begin
					flush_high();
				end
			end
			if (!paired) begin
				if (u == 16'h0000) begin
					string_stopped = 1'b1;
				end else if (u >= SURR_HI_FIRST && u <= SURR_HI_LAST && !at_end) begin
					held_high     = 1'b1;
					held_low_bits = u[9:0];
				end else begin
					emit_code_point({5'd0, u});
				end
			end
		end
		if (last) begin
			if (step_bytes.size() == 0) begin
				marker = '0;
				step_bytes.insert(0, marker);
			end
			step_bytes[step_bytes.size() - 1].str_end = 1'b1;
			held_high      = 1'b0;
			held_low_bits  = '0;
			string_stopped = 1'b0;
			units_seen     = '0;
		end
		if (step_bytes.size() != 0)
			step_bytes[step_bytes.size() - 1].run_end = 1'b1;
		foreach (step_bytes[k])
			due_bytes.insert(due_bytes.size(), step_bytes[k]);
	endtask

	// sender: one item at a time from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				transcode_unit(code_unit, last_unit);
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_units.size() != 0) begin
				next_unit = pending_units.pop_front();
				code_unit <= next_unit.code;
				last_unit <= next_unit.last;
				in_valid  <= 1'b1;
				send_gap  <= draw_gap(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: check each byte, then stall for a randomly drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap  <= 0;
		end else if (out_valid && out_ready) begin
			got_byte = '{data: out_byte, data_ok: byte_valid, run_end: run_last,
				str_end: string_end};
			if (due_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item, expected none actual %0h", $time, got_byte);
			end else begin
				want_byte = due_bytes.pop_front();
				check_field("out_byte", want_byte.data, got_byte.data);
				check_field("byte_valid", 8'(want_byte.data_ok), 8'(got_byte.data_ok));
				check_field("run_last", 8'(want_byte.run_end), 8'(got_byte.run_end));
				check_field("string_end", 8'(want_byte.str_end), 8'(got_byte.str_end));
			end
			recv_draw = draw_gap(recv_calm);
			recv_gap  <= recv_draw;
			out_ready <= (recv_draw == 0);
		end else if (!out_ready) begin
			if (recv_gap != 0)
				recv_gap <= recv_gap - 1;
			else
				out_ready <= 1'b1;
		end
	end

	task automatic push_unit(input logic [15:0] u, input logic last);
		unit_item_t item;
		item = '{code: u, last: last};
		pending_units.insert(pending_units.size(), item);
	endtask

	// wait for every outstanding byte, then let units still in flight settle
	task automatic settle();
		do
			@(negedge clk);
		while (pending_units.size() != 0 || in_valid || due_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_units(input logic [15:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		cap_units   = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_string(input int len, input bit closed);
		int          kind;
		logic [15:0] u;
		for (int i = 0; i < len; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 28)
				u = 16'($urandom_range(1, 16'h7F));
			else if (kind < 42)
				u = 16'($urandom_range(16'h80, 16'h7FF));
			else if (kind < 50)
				u = 16'($urandom_range(16'h800, 16'hD7FF));
			else if (kind < 56)
				u = 16'($urandom_range(16'hE000, 16'hFFFF));
			else if (kind < 76) begin
				// well-formed pair; the low half may fall off the end
				push_unit(16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST)),
					closed && i == len - 1);
				i++;
				if (i >= len)
					break;
				u = 16'($urandom_range(SURR_LO_FIRST, SURR_LO_LAST));
			end else if (kind < 82)
				u = 16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST));
			else if (kind < 88)
				u = 16'($urandom_range(SURR_LO_FIRST, SURR_LO_LAST));
			else if (kind < 91)
				u = 16'h0000;
			else
				u = 16'($urandom_range(0, 16'hFFFF));
			push_unit(u, closed && i == len - 1);
		end
	endtask

	task automatic queue_random_units(input int n);
		int count;
		int len;
		bit closed;
		count = 0;
		while (count < n) begin
			len    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12);
			closed = (count + len < n) || $urandom_range(0, 2) != 0;
			queue_string(len, closed);
			count += len;
		end
	endtask

	initial begin
		logic [15:0] caps[8];
		cap_units      = MAX_UNITS_RESET;
		held_high      = 1'b0;
		held_low_bits  = '0;
		string_stopped = 1'b0;
		units_seen     = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_max_units(MAX_UNITS_RESET);

		// byte-length boundaries, pairs, broken pairs, high surrogate as last unit
		push_unit(16'h0041, 1'b0);
		push_unit(16'h0080, 1'b0);
		push_unit(16'h07FF, 1'b0);
		push_unit(16'h0800, 1'b0);
		push_unit(16'hFFFF, 1'b0);
		push_unit(16'hD800, 1'b0);
		push_unit(16'hDC00, 1'b0);
		push_unit(16'hDBFF, 1'b0);
		push_unit(16'hDFFF, 1'b0);
		push_unit(16'hD801, 1'b0);
		push_unit(16'h0042, 1'b0);
		push_unit(16'hDC00, 1'b0);
		push_unit(16'hD83D, 1'b1);
		// zero unit flushes the held high half and silences the rest
		push_unit(16'hD800, 1'b0);
		push_unit(16'h0000, 1'b0);
		push_unit(16'h0041, 1'b0);
		push_unit(16'h0041, 1'b1);
		push_unit(16'h0000, 1'b1);
		// leave a high surrogate pending, then lower the limit under it
		push_unit(16'h0041, 1'b0);
		push_unit(16'hDBFF, 1'b0);
		settle();
		write_max_units(16'd1);
		push_unit(16'h0041, 1'b0);
		push_unit(16'hFFFF, 1'b1);
		settle();
		// limit lands on a high surrogate
		write_max_units(16'd3);
		push_unit(16'h0041, 1'b0);
		push_unit(16'h0042, 1'b0);
		push_unit(16'hD800, 1'b0);
		push_unit(16'h0044, 1'b1);
		settle();
		write_max_units(16'd0);
		push_unit(16'hFFFF, 1'b1);
		settle();

		caps = '{16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd8, MAX_UNITS_RESET,
			16'($urandom_range(4, 40)), 16'd0};
		foreach (caps[p]) begin
			write_max_units(caps[p]);
			send_calm = (p % 3 == 1);
			recv_calm = (p % 3 == 1) || (p == 4);
			queue_random_units(caps[p] == 16'd0 ? 20 : 58);
			settle();
		end

		if (due_bytes.size() != 0) begin
			mismatches++;
			$display("%0t: outstanding items expected 0 actual %0d", $time, due_bytes.size());
		end
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
